/* src/command_frame_parser_core_defines.svh */
// ----------------------------------------------------------------------------
// command frame parser assertion macros
// shared concurrent assertion forms, clocked on clock, quiet during reset
// ----------------------------------------------------------------------------
`ifndef COMMAND_FRAME_PARSER_CORE_DEFINES_SVH
`define COMMAND_FRAME_PARSER_CORE_DEFINES_SVH

// same-cycle implication
`define CFP_ASSERT_SAME(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("cfp assertion failed");

// next-cycle implication
`define CFP_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("cfp assertion failed");

`endif

/* src/cfp_pkg.sv */
// ----------------------------------------------------------------------------
// cfp_pkg
// constants, phase codes and result type of the command frame parser
// ----------------------------------------------------------------------------
package cfp_pkg;

   localparam int BYTE_WIDTH  = 8;
   localparam int VALUE_WIDTH = 32;
   localparam int SLOT_WIDTH  = 3;

   localparam logic [BYTE_WIDTH-1:0] HEADER_BYTE = 8'hFA;
   localparam logic [BYTE_WIDTH-1:0] TAIL_BYTE_A = 8'hDD;
   localparam logic [BYTE_WIDTH-1:0] TAIL_BYTE_B = 8'hFF;
   localparam logic [BYTE_WIDTH-1:0] MAX_ID      = 8'h07;
   localparam logic [SLOT_WIDTH-1:0] STOP_ID     = 3'd7;
   localparam logic [SLOT_WIDTH-1:0] STOP_SLOT   = 3'd0;
   localparam logic [1:0]            LAST_PAYLOAD = 2'd3;

   localparam int REQ_DATA_WIDTH = 8;
   localparam int RSP_DATA_WIDTH = 40;

   typedef enum logic [2:0] {
      PH_HUNT   = 3'd0,
      PH_ID     = 3'd1,
      PH_DATA   = 3'd2,
      PH_TAIL_A = 3'd3,
      PH_TAIL_B = 3'd4
   } phase_type;

   typedef struct packed {
      logic [SLOT_WIDTH-1:0]  slot_index;
      logic [VALUE_WIDTH-1:0] slot_value;
      logic                   stop_seen;
   } result_type;

endpackage

/* src/command_frame_parser_core.sv */
// ----------------------------------------------------------------------------
// command_frame_parser_core
// recognises command frames in a received byte stream
// ----------------------------------------------------------------------------
// req channel: one received byte per request in req_tdata.
// a frame is FA, id 0..7, four payload bytes (least significant first),
// DD, FF; a bad header, id or tail byte sends the parser back to hunting.
// rsp channel: one request per completed frame with the slot written and
// its new value; id 7 is stop, reported as slot 0, value 0, rsp_tuser high.
// throughput: one byte per cycle while the result register can take a result;
// the state update lies between the input register and the result register.
// the closing FF byte passes the input register, then the result register, before it shows up on rsp.
// reset: parser hunts for a header, input and result registers are empty.
// while rsp_tready is low with a result waiting, req_tready holds low once
// the input register is full; nothing is dropped.
// ----------------------------------------------------------------------------
module command_frame_parser_core
   import cfp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,   // [7:0] rx_byte
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,   // [2:0] slot_index, [34:3] slot_value
   output logic                      rsp_tuser    // [0] stop_seen
);

   logic                  take;
   logic                  byte_valid;
   logic [BYTE_WIDTH-1:0] byte_data;
   logic                  out_ready;
   logic                  res_valid;
   result_type            res;

   cfp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .take       (take),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   cfp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .byte_data  (byte_data),
      .out_ready  (out_ready),
      .take       (take),
      .res_valid  (res_valid),
      .res        (res)
   );

   cfp_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res        (res),
      .out_ready  (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* src/cfp_in_reg.sv */
// ----------------------------------------------------------------------------
// cfp_in_reg
// input register holding one received byte until the parser takes it
// ----------------------------------------------------------------------------
module cfp_in_reg
   import cfp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   input  logic                      take,
   output logic                      byte_valid,
   output logic [BYTE_WIDTH-1:0]     byte_data
);

   logic                  valid_ff;
   logic                  valid_in;
   logic [BYTE_WIDTH-1:0] data_ff;
   logic [BYTE_WIDTH-1:0] data_in;

   assign req_tready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
         data_in  = req_tdata[BYTE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign byte_valid = valid_ff;
   assign byte_data  = data_ff;

endmodule

/* src/cfp_parser.sv */
// ----------------------------------------------------------------------------
// cfp_parser
// frame state machine: header, id, four payload bytes, two tail bytes
// ----------------------------------------------------------------------------
`include "command_frame_parser_core_defines.svh"

module cfp_parser
   import cfp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_valid,
   input  logic [BYTE_WIDTH-1:0] byte_data,
   input  logic                  out_ready,
   output logic                  take,
   output logic                  res_valid,
   output result_type            res
);

   phase_type              phase_ff;
   phase_type              phase_in;
   logic [1:0]             count_ff;
   logic [1:0]             count_in;
   logic [SLOT_WIDTH-1:0]  command_ff;
   logic [SLOT_WIDTH-1:0]  command_in;
   logic [VALUE_WIDTH-1:0] word_ff;
   logic [VALUE_WIDTH-1:0] word_in;
   logic                   step;

   assign step = byte_valid && out_ready;
   assign take = step;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         count_ff   <= 2'd0;
         command_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         command_ff <= command_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   always_comb begin
      phase_in       = phase_ff;
      count_in       = count_ff;
      command_in     = command_ff;
      word_in        = word_ff;
      res_valid      = 1'b0;
      res.slot_index = command_ff;
      res.slot_value = word_ff;
      res.stop_seen  = 1'b0;
      if (step) begin
         unique case (phase_ff)
            PH_ID: begin
               if (byte_data <= MAX_ID) begin
                  command_in = byte_data[SLOT_WIDTH-1:0];
                  phase_in   = PH_DATA;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_DATA: begin
               word_in[{count_ff, 3'b000} +: BYTE_WIDTH] = byte_data;
               count_in = count_ff + 2'd1;
               if (count_ff == LAST_PAYLOAD) begin
                  phase_in = PH_TAIL_A;
               end
            end
            PH_TAIL_A: begin
               phase_in = (byte_data == TAIL_BYTE_A) ? PH_TAIL_B : PH_HUNT;
            end
            PH_TAIL_B: begin
               phase_in = PH_HUNT;
               if (byte_data == TAIL_BYTE_B) begin
                  res_valid = 1'b1;
                  if (command_ff == STOP_ID) begin
                     res.slot_index = STOP_SLOT;
                     res.slot_value = '0;
                     res.stop_seen  = 1'b1;
                  end
               end
            end
            default: begin
               phase_in = (byte_data == HEADER_BYTE) ? PH_ID : PH_HUNT;
            end
         endcase
      end
   end

   `CFP_ASSERT_NEXT(a_idle_holds, !step, $stable(phase_ff) && $stable(count_ff))
   `CFP_ASSERT_NEXT(a_fourth_payload,
      step && phase_ff == PH_DATA && count_ff == LAST_PAYLOAD,
      phase_ff == PH_TAIL_A && count_ff == 2'd0)
   `CFP_ASSERT_SAME(a_stop_clears_slot0, res_valid && res.stop_seen,
      res.slot_index == STOP_SLOT && res.slot_value == '0)
   `CFP_ASSERT_NEXT(a_result_rehunts, res_valid, phase_ff == PH_HUNT)

endmodule

/* src/cfp_out_reg.sv */
// ----------------------------------------------------------------------------
// cfp_out_reg
// result register towards the response channel
// ----------------------------------------------------------------------------
module cfp_out_reg
   import cfp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      res_valid,
   input  result_type                res,
   output logic                      out_ready,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic                      rsp_tuser
);

   logic       valid_ff;
   logic       valid_in;
   result_type res_ff;
   result_type res_in;

   assign out_ready = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (out_ready) begin
         valid_in = res_valid;
         res_in   = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH - VALUE_WIDTH - SLOT_WIDTH){1'b0}},
                        res_ff.slot_value, res_ff.slot_index};
   assign rsp_tuser  = res_ff.stop_seen;

endmodule
